/* src/encoder_position_speed_meter_assert.svh */
// Assertion macros for the encoder position and speed meter.
`ifndef ENCODER_POSITION_SPEED_METER_ASSERT_SVH
`define ENCODER_POSITION_SPEED_METER_ASSERT_SVH

// Same-cycle implication.
`define EPSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EPSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/epsm_pkg.sv */
// Shared constants and types of the encoder position and speed meter.
package epsm_pkg;

  localparam int CHANNELS  = 6;
  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W      = 3;
  localparam int PPR_W     = 16;
  localparam int EL_W      = 32;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;

  localparam int US_W      = 26;
  localparam logic [US_W-1:0] US_PER_MIN = US_W'(60000000);
  localparam int PROD_W    = DATA_W + US_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int DEN_W     = PPR_W + EL_W;
  localparam int Q_W       = DATA_W - 1;
  localparam int HI_W      = NUM_W - Q_W;
  localparam int CNT_W     = $clog2(Q_W + 1);

  localparam logic [16:0] W_KEEP = 17'd55706;
  localparam logic [12:0] W_RAW  = 13'd4915;
  localparam int P1_W  = 50;
  localparam int P2_W  = 47;
  localparam int SUM_W = 51;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

  localparam logic [DATA_W-1:0] RAW_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] RAW_MIN = 32'h8000_0000;

  localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(1);

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] smoothed;
    logic [DATA_W-1:0] last_raw;
    logic [DATA_W-1:0] pos_last;
    logic [DATA_W-1:0] count;
  } epsm_entry_t;

  typedef struct packed {
    logic done;
    logic sat;
  } epsm_div_st_t;

endpackage

/* src/encoder_position_speed_meter.sv */
// Top level of the encoder position and speed meter: channel memory and sequencer.
// Edge item: S_READ updates the count and S_OUT registers the result; the next item is taken once S_OUT is left.
// Update item: the result passes S_MUL, S_DIVST, the 31-step divider in S_DIV, S_FILT and S_SUM.
// One item at a time; per-channel state in one memory with a registered read port.
// rst_n (synchronous, low) clears the per-channel valid bits, so all state reads as zero.
// pulses_per_rev resets to 1.
`include "encoder_position_speed_meter_assert.svh"

module encoder_position_speed_meter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [epsm_pkg::PPR_W-1:0]        cfg_pulses_per_rev,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [epsm_pkg::CH_W-1:0]         in_channel,
  input  logic                              in_b_level,
  input  logic [epsm_pkg::EL_W-1:0]         in_elapsed_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [epsm_pkg::DATA_W-1:0] out_position,
  output logic signed [epsm_pkg::DATA_W-1:0] out_raw_speed,
  output logic signed [epsm_pkg::DATA_W-1:0] out_filtered_speed
);
  import epsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_DIVST, S_DIV, S_FILT, S_SUM, S_OUT
  } state_t;

  state_t              state_r;
  logic [PPR_W-1:0]    ppr_r;

  epsm_entry_t         mem [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  epsm_entry_t         rd_data_r;
  logic                rd_hit_r;

  logic                op_r;
  logic                b_r;
  logic                ok_r;
  logic [CH_AW-1:0]    addr_r;
  logic [EL_W-1:0]     el_r;
  epsm_entry_t         ent_r;
  logic                neg_r;
  logic [DATA_W-1:0]   mag_r;
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;
  logic signed [P1_W-1:0] p1_r;
  logic signed [P2_W-1:0] p2_r;
  logic [DATA_W-1:0]   raw_r;
  logic [DATA_W-1:0]   res_pos_r;
  logic [DATA_W-1:0]   res_raw_r;
  logic [DATA_W-1:0]   res_filt_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_pos_r;
  logic [DATA_W-1:0]   out_raw_r;
  logic [DATA_W-1:0]   out_filt_r;

  logic                accept;
  logic                in_ok;
  logic [CH_AW-1:0]    in_addr;
  epsm_entry_t         ent_rd;
  logic [DATA_W-1:0]   cnt_new;
  logic [DATA_W-1:0]   diff;
  logic [PROD_W-1:0]   num_prod;
  logic [DATA_W:0]     rsum;
  logic [SUM_W-1:0]    fsum;
  logic [DATA_W-1:0]   filt;
  logic [DATA_W-1:0]   qx;
  logic [DATA_W-1:0]   raw_div;
  logic                mem_we;
  epsm_entry_t         wr_data;
  logic                div_start;
  epsm_div_st_t        div_st;
  logic [Q_W-1:0]      div_q;
  logic                out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_ok     = int'(in_channel) < CHANNELS;
  assign in_addr   = CH_AW'(in_channel);

  assign ent_rd   = rd_hit_r ? rd_data_r : '0;
  assign cnt_new  = b_r ? ent_rd.count + DATA_W'(1) : ent_rd.count - DATA_W'(1);
  assign diff     = ent_rd.count - ent_rd.pos_last;
  assign num_prod = PROD_W'(mag_r) * PROD_W'(US_PER_MIN);
  assign rsum     = {raw_r[DATA_W-1], raw_r} + {ent_r.last_raw[DATA_W-1], ent_r.last_raw};
  assign fsum     = SUM_W'(p1_r) + SUM_W'(p2_r) + ROUND_HALF;
  assign filt     = fsum[DATA_W+15:16];
  assign qx       = {1'b0, div_q};
  assign raw_div  = neg_r ? (div_st.sat ? RAW_MIN : (-qx))
                          : (div_st.sat ? RAW_MAX : qx);
  assign div_start = (state_r == S_DIVST) && (den_r != '0);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    mem_we  = 1'b0;
    wr_data = ent_rd;
    case (state_r)
      S_READ: begin
        mem_we        = ok_r && (op_r == OP_EDGE);
        wr_data.count = cnt_new;
      end
      S_SUM: begin
        mem_we           = 1'b1;
        wr_data          = ent_r;
        wr_data.smoothed = filt;
        wr_data.last_raw = raw_r;
        wr_data.pos_last = ent_r.count;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  epsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .st    (div_st),
    .quo   (div_q)
  );

  // channel memory; writes only happen while no item is being taken
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wr_data;
    end
    if (accept && in_ok) begin
      rd_data_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
      ppr_r    <= PPR_RESET;
    end else begin
      if (mem_we) begin
        valid_r[addr_r] <= 1'b1;
      end
      if (accept) begin
        rd_hit_r <= in_ok && valid_r[in_addr];
      end
      if (cfg_valid && cfg_ready) begin
        ppr_r <= cfg_pulses_per_rev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_operation;
            b_r     <= in_b_level;
            ok_r    <= in_ok;
            addr_r  <= in_addr;
            el_r    <= in_elapsed_us;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (!ok_r) begin
            res_pos_r  <= '0;
            res_raw_r  <= '0;
            res_filt_r <= '0;
            state_r    <= S_OUT;
          end else if (op_r == OP_EDGE) begin
            res_pos_r  <= cnt_new;
            res_raw_r  <= ent_rd.last_raw;
            res_filt_r <= ent_rd.smoothed;
            state_r    <= S_OUT;
          end else begin
            ent_r   <= ent_rd;
            neg_r   <= diff[DATA_W-1];
            mag_r   <= diff[DATA_W-1] ? (ent_rd.pos_last - ent_rd.count) : diff;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          num_r   <= {num_prod, FRAC_BITS'(0)};
          den_r   <= DEN_W'(ppr_r) * DEN_W'(el_r);
          p1_r    <= $signed({1'b0, W_KEEP}) * $signed(ent_r.smoothed);
          state_r <= S_DIVST;
        end
        S_DIVST: begin
          if (den_r == '0) begin
            raw_r   <= '0;
            state_r <= S_FILT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            raw_r   <= raw_div;
            state_r <= S_FILT;
          end
        end
        S_FILT: begin
          p2_r    <= $signed({1'b0, W_RAW}) * $signed(rsum);
          state_r <= S_SUM;
        end
        S_SUM: begin
          res_pos_r  <= ent_r.count;
          res_raw_r  <= raw_r;
          res_filt_r <= filt;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_pos_r   <= res_pos_r;
            out_raw_r   <= res_raw_r;
            out_filt_r  <= res_filt_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position       = $signed(out_pos_r);
  assign out_raw_speed      = $signed(out_raw_r);
  assign out_filtered_speed = $signed(out_filt_r);

  `EPSM_ASSERT_NOW(a_wr_while_busy, mem_we, !in_ready, "channel memory written while idle")
  `EPSM_ASSERT_NOW(a_div_done_in_wait, div_st.done, state_r == S_DIV, "divider done outside wait")
  `EPSM_ASSERT_NEXT(a_result_issued, out_load, out_valid && (state_r == S_IDLE), "result lost")

endmodule

/* src/epsm_div.sv */
// Restoring divider, one quotient bit per cycle, with overflow detection.
module epsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [epsm_pkg::NUM_W-1:0] num,
  input  logic [epsm_pkg::DEN_W-1:0] den,
  output epsm_pkg::epsm_div_st_t     st,
  output logic [epsm_pkg::Q_W-1:0]   quo
);
  import epsm_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic                sat_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DEN_W-1:0]    rem_r;
  logic [DEN_W-1:0]    den_r;
  logic [Q_W-1:0]      low_r;
  logic [Q_W-1:0]      q_r;

  logic [HI_W-1:0]     hi;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;
  logic                fits;

  assign hi    = num[NUM_W-1:Q_W];
  assign trial = {rem_r, low_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= DEN_W'(hi);
        den_r  <= den;
        low_r  <= num[Q_W-1:0];
        sat_r  <= DEN_W'(hi) >= den;
        cnt_r  <= CNT_W'(Q_W);
        q_r    <= '0;
      end else if (busy_r) begin
        if (sat_r || cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          q_r   <= {q_r[Q_W-2:0], fits};
          low_r <= {low_r[Q_W-2:0], 1'b0};
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign st.done = done_r;
  assign st.sat  = sat_r;
  assign quo     = q_r;

endmodule
